@@ rtl/pdsfmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsfmd_pkg
// Shared widths, codes and control structs of the four-motor PD steering block.
// ----------------------------------------------------------------------------
package pdsfmd_pkg;
    localparam int SAMPLE_BITS     = 12;
    localparam int ERROR_FRAC_BITS = 14;
    localparam int ERR_W           = ERROR_FRAC_BITS + 2;
    localparam int NUM_W           = SAMPLE_BITS + 1 + ERROR_FRAC_BITS;
    localparam int SUM_W           = SAMPLE_BITS + 1;
    localparam int QUO_W           = NUM_W;
    localparam int DIV_STEPS       = NUM_W;
    localparam int DCNT_W          = $clog2(DIV_STEPS + 1);
    localparam int GAIN_W          = 12;
    localparam int PROD_W          = ERR_W + 1 + GAIN_W + 1;
    localparam int ACC_W           = PROD_W + 1;
    localparam int STEER_SHIFT     = ERROR_FRAC_BITS + 4;
    localparam int DUTY_W          = 7;
    localparam int DIR_W           = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 12;
    localparam int WORK_W          = 12;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFTRACK   = 2'd3;

    localparam logic [DIR_W-1:0] DIR_BRAKE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV   = 2'd2;

    typedef struct packed {
        logic load;      // capture input item, set up divider
        logic div_step;  // one restoring division step
        logic mul_p;     // e * prop_gain into accumulator
        logic mul_d;     // add d * deriv_gain
        logic finish;    // form duties and directions
    } pdsfmd_cmd_t;

    typedef struct packed {
        logic div_done;
    } pdsfmd_sts_t;
endpackage

@@ rtl/pd_steering_four_motor_drive_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_steering_four_motor_drive_unit
// Difference-over-sum PD steering for a four-motor car.
// ----------------------------------------------------------------------------
// Each item goes through a load step, 27 steps of the restoring divider for
// (L-R)*2^14/(L+R), a check that the divider is done, two passes of the shared
// gain multiplier and a step that forms the duties; the result is then held
// until taken and the next item is accepted in the cycle after that.
module pd_steering_four_motor_drive_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // left_sample[11:0], right_sample[23:12]
    input  logic        s_tuser,   // stop_request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // fl_duty, fr_duty, rl_duty, rr_duty (7b each),
                                   // fl_dir, fr_dir, rl_dir, rr_dir (2b each), 4b zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import pdsfmd_pkg::*;

    pdsfmd_cmd_t cmd;
    pdsfmd_sts_t sts;
    logic [DUTY_W-1:0] ld, rd;
    logic [DIR_W-1:0]  ldir, rdir;

    assign cfg_ready = 1'b1;

    pdsfmd_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd, .sts
    );

    pdsfmd_datapath u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .left_sample(s_tdata[11:0]), .right_sample(s_tdata[23:12]),
        .stop_request(s_tuser),
        .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .left_duty(ld), .right_duty(rd), .left_dir(ldir), .right_dir(rdir)
    );

    assign m_tdata = {4'b0, rdir, ldir, rdir, ldir, rd, ld, rd, ld};
endmodule

@@ rtl/pdsfmd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsfmd_datapath
// Serial divider, shared gain multiplier and duty/direction rules.
// ----------------------------------------------------------------------------
module pdsfmd_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  pdsfmd_pkg::pdsfmd_cmd_t                cmd,
    output pdsfmd_pkg::pdsfmd_sts_t                sts,
    input  logic [pdsfmd_pkg::SAMPLE_BITS-1:0]     left_sample,
    input  logic [pdsfmd_pkg::SAMPLE_BITS-1:0]     right_sample,
    input  logic                                   stop_request,
    input  logic                                   cfg_we,
    input  logic [pdsfmd_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [pdsfmd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [pdsfmd_pkg::DUTY_W-1:0]          left_duty,
    output logic [pdsfmd_pkg::DUTY_W-1:0]          right_duty,
    output logic [pdsfmd_pkg::DIR_W-1:0]           left_dir,
    output logic [pdsfmd_pkg::DIR_W-1:0]           right_dir
);
    import pdsfmd_pkg::*;

    logic [DUTY_W-1:0]      base_reg;
    logic [GAIN_W-1:0]      pgain_reg, dgain_reg;
    logic [SAMPLE_BITS-1:0] offtrk_reg;
    logic signed [ERR_W-1:0] prev_err_reg;

    logic [SAMPLE_BITS-1:0] l_reg, r_reg;
    logic                   stop_reg, neg_reg, zero_reg;
    logic [SUM_W-1:0]       den_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [SUM_W:0]         rem_reg;
    logic [DCNT_W-1:0]      cnt_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ERR_W-1:0] err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= DUTY_W'(50);
            pgain_reg    <= GAIN_W'(800);
            dgain_reg    <= GAIN_W'(160);
            offtrk_reg   <= SAMPLE_BITS'(200);
            prev_err_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_BASE_SPEED: base_reg   <= cfg_data[DUTY_W-1:0];
                    REG_PROP_GAIN:  pgain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN: dgain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_OFFTRACK:   offtrk_reg <= cfg_data[SAMPLE_BITS-1:0];
                    default: ;
                endcase
            end
            if (cmd.mul_d) prev_err_reg <= err_reg;
        end
    end

    // divider: magnitude of (L-R)<<F over L+R, restoring, one bit per step
    logic [SAMPLE_BITS-1:0] mag;
    logic [SUM_W:0]         trial;
    assign mag   = (left_sample >= right_sample) ? left_sample - right_sample
                                                 : right_sample - left_sample;
    assign trial = {rem_reg[SUM_W-1:0], num_reg[NUM_W-1]};
    assign sts.div_done = (cnt_reg == DCNT_W'(DIV_STEPS));

    // quotient bits collect in num_reg as it shifts
    logic signed [ERR_W-1:0] e_now;
    assign e_now = zero_reg ? '0 :
        (neg_reg ? -ERR_W'(num_reg) : ERR_W'(num_reg));

    logic signed [ERR_W:0]    d_now;
    logic signed [ERR_W:0]    mop;
    logic signed [GAIN_W:0]   gop;
    logic signed [PROD_W-1:0] prod;
    assign d_now = ERR_W'(0) + ({err_reg[ERR_W-1], err_reg} -
                                {prev_err_reg[ERR_W-1], prev_err_reg});
    assign mop  = cmd.mul_p ? {e_now[ERR_W-1], e_now} : d_now;
    assign gop  = cmd.mul_p ? {1'b0, pgain_reg} : {1'b0, dgain_reg};
    assign prod = PROD_W'(mop * gop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load) begin
            l_reg    <= left_sample;
            r_reg    <= right_sample;
            stop_reg <= stop_request;
            neg_reg  <= right_sample > left_sample;
            den_reg  <= SUM_W'(left_sample) + SUM_W'(right_sample);
            zero_reg <= (left_sample == '0) && (right_sample == '0);
            num_reg  <= {1'b0, mag, ERROR_FRAC_BITS'(0)};
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_reg <= trial - {1'b0, den_reg};
                num_reg <= {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial;
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.mul_p) begin
            err_reg <= e_now;
            acc_reg <= ACC_W'(prod);
        end else if (cmd.mul_d) begin
            acc_reg <= acc_reg + ACC_W'(prod);
        end
    end

    // truncate toward zero
    logic signed [ACC_W-1:0] acc_adj, st_full;
    logic signed [WORK_W-1:0] st, lft0, rgt0, lft1, rgt1, lft2, rgt2, lp, rp;
    logic [DIR_W-1:0] ld, rd;
    assign acc_adj = acc_reg[ACC_W-1] ? acc_reg + ACC_W'((1 << STEER_SHIFT) - 1) : acc_reg;
    assign st_full = acc_adj >>> STEER_SHIFT;
    assign st      = WORK_W'(st_full);
    assign lp      = WORK_W'(100) - (st <<< 1);
    assign rp      = WORK_W'(100) + (st <<< 1);

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [WORK_W-1:0] v);
        if (v < 1) return '0;
        else if (v > 99) return DUTY_W'(100);
        else return v[DUTY_W-1:0];
    endfunction

    always_comb begin
        lft0 = WORK_W'({1'b0, base_reg}) - st;
        rgt0 = WORK_W'({1'b0, base_reg}) + st;
        rgt1 = (lft0 > 99) ? rp : rgt0;
        lft1 = (rgt1 > 99) ? lp : lft0;
        lft2 = lft1;
        rgt2 = rgt1;
        ld = DIR_BRAKE;
        rd = DIR_BRAKE;
        if (!stop_reg) begin
            ld = DIR_FWD;
            rd = DIR_FWD;
            if (lft1 < 0) begin
                lft2 = -lp;
                ld   = DIR_REV;
            end
            if (rgt1 < 0) begin
                rgt2 = -rp;
                rd   = DIR_REV;
            end
        end
    end

    logic offtrk;
    assign offtrk = (l_reg < offtrk_reg) && (r_reg < offtrk_reg);

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            left_duty  <= offtrk ? '0 : clamp_duty(lft2);
            right_duty <= offtrk ? '0 : clamp_duty(rgt2);
            left_dir   <= ld;
            right_dir  <= rd;
        end
    end
endmodule

@@ rtl/pdsfmd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsfmd_ctrl
// Sequencer: accept, divide, multiply twice, finish, hold result.
// ----------------------------------------------------------------------------
module pdsfmd_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output pdsfmd_pkg::pdsfmd_cmd_t cmd,
    input  pdsfmd_pkg::pdsfmd_sts_t sts
);
    import pdsfmd_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_MULP, S_MULD, S_FIN, S_OUT} state_t;
    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;

    always_comb begin
        cmd = '0;
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        case (state_reg)
            S_IDLE: if (in_valid && in_ready) begin
                cmd.load   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: if (sts.div_done) state_next = S_MULP;
                   else cmd.div_step = 1'b1;
            S_MULP: begin
                cmd.mul_p  = 1'b1;
                state_next = S_MULD;
            end
            S_MULD: begin
                cmd.mul_d  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                cmd.finish  = 1'b1;
                ovalid_next = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: if (out_ready) begin
                ovalid_next = 1'b0;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

@@ rtl/pdsfmd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsfmd_checker
// Port-level checks on the steering block.
// ----------------------------------------------------------------------------
module pdsfmd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request taken while result pending");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid && !s_tready)
        else $error("result too early");
    a_sides: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:0] == m_tdata[20:14] && m_tdata[13:7] == m_tdata[27:21])
        else $error("front and rear duties differ");
endmodule

bind pd_steering_four_motor_drive_unit pdsfmd_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
